>>> sv/casb_pkg.sv
// shared types, constants and the pixel blend function of the clipped alpha stamp blitter
package casb_pkg;

    // canvas store geometry
    localparam int MAX_CANVAS_WIDTH  = 256;
    localparam int MAX_CANVAS_HEIGHT = 256;
    localparam int CANVAS_WORDS      = MAX_CANVAS_WIDTH * MAX_CANVAS_HEIGHT;
    localparam int ADDR_W            = (CANVAS_WORDS > 1) ? $clog2(CANVAS_WORDS) : 1;

    // field widths
    localparam int PIX_W      = 32;
    localparam int IDX_W      = 16;
    localparam int CDIM_W     = 9;
    localparam int SDIM_W     = 10;
    localparam int POS_W      = 10;
    localparam int CNT_W      = 9;
    localparam int COORD_W    = 11;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 10;

    typedef logic [PIX_W-1:0]      pix_t;
    typedef logic [IDX_W-1:0]      idx_t;
    typedef logic [ADDR_W-1:0]     addr_t;
    typedef logic [CDIM_W-1:0]     cdim_t;
    typedef logic [SDIM_W-1:0]     sdim_t;
    typedef logic [CNT_W-1:0]      cnt_t;
    typedef logic [CFG_IDX_W-1:0]  cfg_idx_t;
    typedef logic [CFG_DATA_W-1:0] cfg_data_t;

    // canvas size limits as seen by the 9-bit size registers
    localparam int    CW_CAP   = (MAX_CANVAS_WIDTH > 511) ? 511 : MAX_CANVAS_WIDTH;
    localparam int    CH_CAP   = (MAX_CANVAS_HEIGHT > 511) ? 511 : MAX_CANVAS_HEIGHT;
    localparam cdim_t CW_LIMIT = cdim_t'(CW_CAP);
    localparam cdim_t CH_LIMIT = cdim_t'(CH_CAP);
    localparam sdim_t SURF_MAX = sdim_t'(512);
    localparam sdim_t SURF_MIN = sdim_t'(1);

    // blend masks
    localparam pix_t       RB_MASK      = 32'h00FF00FF;
    localparam pix_t       G_MASK       = 32'h0000FF00;
    localparam logic [7:0] ALPHA_OPAQUE = 8'hFF;
    localparam int         ALPHA_LSB    = 24;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_CANVAS_WIDTH   = 3'd0,
        REG_CANVAS_HEIGHT  = 3'd1,
        REG_STAMP_X        = 3'd2,
        REG_STAMP_Y        = 3'd3,
        REG_SURFACE_WIDTH  = 3'd4,
        REG_SURFACE_HEIGHT = 3'd5
    } cfg_reg_t;

    typedef struct packed {
        cdim_t              canvas_width;
        cdim_t              canvas_height;
        logic signed [POS_W-1:0] stamp_x;
        logic signed [POS_W-1:0] stamp_y;
        sdim_t              surface_width;
        sdim_t              surface_height;
    } cfg_t;

    // where the current surface pixel lands
    typedef struct packed {
        logic  on_canvas;
        addr_t addr;
        logic  last;
    } loc_t;

    // alpha 255 copies the source, otherwise wrapping 32-bit blend of r/b and g
    function automatic pix_t blend_pixel(input pix_t src, input pix_t bg);
        pix_t alpha;
        pix_t rb;
        pix_t g;
        pix_t rb_mix;
        pix_t g_mix;
        pix_t result;
        alpha  = {24'd0, src[ALPHA_LSB +: 8]};
        rb     = bg & RB_MASK;
        g      = bg & G_MASK;
        rb_mix = rb + ((((src & RB_MASK) - rb) * alpha) >> 8);
        g_mix  = g + ((((src & G_MASK) - g) * alpha) >> 8);
        if (src[ALPHA_LSB +: 8] == ALPHA_OPAQUE)
        begin
            result = src;
        end
        else
        begin
            result = (rb_mix & RB_MASK) | (g_mix & G_MASK);
        end
        return result;
    endfunction

endpackage

>>> sv/casb_ram.sv
// generic single-write, single-read synchronous ram with registered read data
module casb_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // read returns old data on a same-address write
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata <= mem[raddr];
        end
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

endmodule

>>> sv/casb_locate.sv
// surface row/column counters, clipping and canvas address of the next pixel
module casb_locate (
    input  logic           clk,
    input  logic           rst_n,
    input  casb_pkg::cfg_t cfg,
    input  logic           step,
    output casb_pkg::loc_t loc
);

    casb_pkg::cnt_t col_reg, col_next;
    casb_pkg::cnt_t row_reg, row_next;

    casb_pkg::cdim_t cw_eff;
    casb_pkg::cdim_t ch_eff;
    casb_pkg::sdim_t sw_eff;
    casb_pkg::sdim_t sh_eff;
    logic signed [casb_pkg::COORD_W-1:0] cx;
    logic signed [casb_pkg::COORD_W-1:0] cy;
    logic [19:0] idx_full;
    logic        last_col;
    logic        last_row;

    always_comb
    begin
        cw_eff = (cfg.canvas_width > casb_pkg::CW_LIMIT) ? casb_pkg::CW_LIMIT
                                                          : cfg.canvas_width;
        ch_eff = (cfg.canvas_height > casb_pkg::CH_LIMIT) ? casb_pkg::CH_LIMIT
                                                           : cfg.canvas_height;

        if (cfg.surface_width == '0)
            sw_eff = casb_pkg::SURF_MIN;
        else if (cfg.surface_width > casb_pkg::SURF_MAX)
            sw_eff = casb_pkg::SURF_MAX;
        else
            sw_eff = cfg.surface_width;

        if (cfg.surface_height == '0)
            sh_eff = casb_pkg::SURF_MIN;
        else if (cfg.surface_height > casb_pkg::SURF_MAX)
            sh_eff = casb_pkg::SURF_MAX;
        else
            sh_eff = cfg.surface_height;

        cx = $signed({cfg.stamp_x[casb_pkg::POS_W-1], cfg.stamp_x})
           + $signed({2'b00, col_reg});
        cy = $signed({cfg.stamp_y[casb_pkg::POS_W-1], cfg.stamp_y})
           + $signed({2'b00, row_reg});

        loc.on_canvas = !cx[casb_pkg::COORD_W-1] && !cy[casb_pkg::COORD_W-1]
                     && (cx[9:0] < {1'b0, cw_eff}) && (cy[9:0] < {1'b0, ch_eff});

        // inside the canvas the index always stays below the store depth
        idx_full = (20'(cy[9:0]) * 20'(cw_eff)) + 20'(cx[9:0]);
        loc.addr = casb_pkg::addr_t'(idx_full);

        last_col = ({1'b0, col_reg} + 10'd1) >= sw_eff;
        last_row = ({1'b0, row_reg} + 10'd1) >= sh_eff;
        loc.last = last_col && last_row;

        col_next = col_reg;
        row_next = row_reg;
        if (step)
        begin
            if (last_col)
            begin
                col_next = '0;
                row_next = last_row ? '0 : row_reg + 9'd1;
            end
            else
            begin
                col_next = col_reg + 9'd1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg <= '0;
            row_reg <= '0;
        end
        else
        begin
            col_reg <= col_next;
            row_reg <= row_next;
        end
    end

endmodule

>>> sv/clipped_alpha_stamp_blitter.sv
// top level of the clipped alpha stamp blitter: config, canvas store, blend stage, output beat
//
// Surface pixels (ARGB8888) stream in on s_axis in raster order and are stamped
// onto a canvas held in an internal 64K x 32 synchronous ram, with the surface's
// top-left corner at the signed canvas position (stamp_x, stamp_y). Every input
// beat gives exactly one output beat carrying the canvas index and new value of
// the destination pixel, with tuser high when the pixel lay on the canvas and
// was written (index and value are zero otherwise) and tlast on the last pixel
// of the surface. After reset the canvas is cleared by a sweep that writes one
// word a cycle: s_axis_tready stays low until the sweep has covered every word,
// while the config port is taken as usual. After that the block takes one pixel
// per clock while m_axis is not stalled: a beat gets its address generated and
// its ram read issued, moves into the blend stage for blend and write-back, and
// then sits in the output register. A pixel that hits the same canvas word as the
// one just before it gets the fresh value from a one-entry write forward path.
// Config writes apply from the next pixel on and must only be made while idle.
module clipped_alpha_stamp_blitter (
    input  logic                      clk,
    input  logic                      rst_n,

    // pixel input: tdata = surface_pixel[31:0]
    input  logic                      s_axis_tvalid,
    output logic                      s_axis_tready,
    input  logic [31:0]               s_axis_tdata,

    // result output: tdata = canvas_index[15:0], canvas_value[47:16]
    output logic                      m_axis_tvalid,
    input  logic                      m_axis_tready,
    output logic [47:0]               m_axis_tdata,
    output logic                      m_axis_tuser,   // written
    output logic                      m_axis_tlast,   // end_of_stamp

    // register write port
    input  logic                      cfg_valid,
    output logic                      cfg_ready,
    input  casb_pkg::cfg_idx_t        cfg_index,
    input  casb_pkg::cfg_data_t       cfg_data
);

    casb_pkg::cfg_t  cfg_reg, cfg_next;
    casb_pkg::loc_t  loc;

    // clear sweep
    logic            clr_active_reg, clr_active_next;
    casb_pkg::addr_t clr_addr_reg, clr_addr_next;

    // blend stage
    logic            s1_valid_reg, s1_valid_next;
    casb_pkg::pix_t  s1_pix_reg;
    casb_pkg::addr_t s1_addr_reg;
    logic            s1_inside_reg;
    logic            s1_last_reg;

    // last canvas write, for back-to-back hits on one word
    logic            fwd_valid_reg, fwd_valid_next;
    casb_pkg::addr_t fwd_addr_reg;
    casb_pkg::pix_t  fwd_data_reg;

    // output beat
    logic            out_valid_reg, out_valid_next;
    casb_pkg::idx_t  out_index_reg;
    casb_pkg::pix_t  out_value_reg;
    logic            out_written_reg;
    logic            out_last_reg;

    logic            take;
    logic            s1_adv;
    logic            s1_commit;
    logic            item_we;
    casb_pkg::pix_t  rd_data;
    casb_pkg::pix_t  bg;
    casb_pkg::pix_t  new_val;
    logic            ram_we;
    casb_pkg::addr_t ram_waddr;
    casb_pkg::pix_t  ram_wdata;

    // ---------------------------------------------------------------- config
    assign cfg_ready = 1'b1;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_valid)
        begin
            case (casb_pkg::cfg_reg_t'(cfg_index))
                casb_pkg::REG_CANVAS_WIDTH:
                    cfg_next.canvas_width = casb_pkg::cdim_t'(cfg_data);
                casb_pkg::REG_CANVAS_HEIGHT:
                    cfg_next.canvas_height = casb_pkg::cdim_t'(cfg_data);
                casb_pkg::REG_STAMP_X:
                    cfg_next.stamp_x = $signed(cfg_data);
                casb_pkg::REG_STAMP_Y:
                    cfg_next.stamp_y = $signed(cfg_data);
                casb_pkg::REG_SURFACE_WIDTH:
                    cfg_next.surface_width = cfg_data;
                casb_pkg::REG_SURFACE_HEIGHT:
                    cfg_next.surface_height = cfg_data;
                default:
                    cfg_next = cfg_reg;  // unknown index, write dropped
            endcase
        end
    end

    // ---------------------------------------------------------------- handshake
    // blend stage moves on whenever the output register is empty or draining
    assign s1_adv        = !out_valid_reg || m_axis_tready;
    assign s_axis_tready = !clr_active_reg && (!s1_valid_reg || s1_adv);
    assign take          = s_axis_tvalid && s_axis_tready;
    assign s1_commit     = s1_valid_reg && s1_adv;
    assign item_we       = s1_commit && s1_inside_reg;

    // ---------------------------------------------------------------- locate
    casb_locate u_locate (
        .clk   (clk),
        .rst_n (rst_n),
        .cfg   (cfg_reg),
        .step  (take),
        .loc   (loc)
    );

    // ---------------------------------------------------------------- canvas store
    // the sweep owns the write port until it ends; no pixel is in flight then
    assign ram_we    = clr_active_reg || item_we;
    assign ram_waddr = clr_active_reg ? clr_addr_reg : s1_addr_reg;
    assign ram_wdata = clr_active_reg ? '0 : new_val;

    casb_ram #(
        .WIDTH (casb_pkg::PIX_W),
        .DEPTH (casb_pkg::CANVAS_WORDS)
    ) u_canvas (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (take),
        .raddr (loc.addr),
        .rdata (rd_data)
    );

    // ---------------------------------------------------------------- blend
    // the ram read of this pixel may have been issued on the edge the previous write landed,
    // so a match with the last write takes the forwarded word
    always_comb
    begin
        bg      = (fwd_valid_reg && (fwd_addr_reg == s1_addr_reg)) ? fwd_data_reg : rd_data;
        new_val = casb_pkg::blend_pixel(s1_pix_reg, bg);
    end

    // ---------------------------------------------------------------- next state
    always_comb
    begin
        clr_active_next = clr_active_reg;
        clr_addr_next   = clr_addr_reg;
        if (clr_active_reg)
        begin
            clr_addr_next = clr_addr_reg + casb_pkg::addr_t'(1);
            if (clr_addr_reg == casb_pkg::addr_t'(casb_pkg::CANVAS_WORDS - 1))
            begin
                clr_active_next = 1'b0;
            end
        end

        if (take)
            s1_valid_next = 1'b1;
        else if (s1_commit)
            s1_valid_next = 1'b0;
        else
            s1_valid_next = s1_valid_reg;

        fwd_valid_next = fwd_valid_reg || item_we;

        if (s1_commit)
            out_valid_next = 1'b1;
        else if (m_axis_tready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.canvas_width   <= casb_pkg::cdim_t'(256);
            cfg_reg.canvas_height  <= casb_pkg::cdim_t'(256);
            cfg_reg.stamp_x        <= '0;
            cfg_reg.stamp_y        <= '0;
            cfg_reg.surface_width  <= casb_pkg::SURF_MIN;
            cfg_reg.surface_height <= casb_pkg::SURF_MIN;
            clr_active_reg         <= 1'b1;
            clr_addr_reg           <= '0;
            s1_valid_reg           <= 1'b0;
            fwd_valid_reg          <= 1'b0;
            out_valid_reg          <= 1'b0;
        end
        else
        begin
            cfg_reg        <= cfg_next;
            clr_active_reg <= clr_active_next;
            clr_addr_reg   <= clr_addr_next;
            s1_valid_reg   <= s1_valid_next;
            fwd_valid_reg  <= fwd_valid_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    // payload
    always_ff @(posedge clk)
    begin
        if (take)
        begin
            s1_pix_reg    <= s_axis_tdata;
            s1_addr_reg   <= loc.addr;
            s1_inside_reg <= loc.on_canvas;
            s1_last_reg   <= loc.last;
        end
        if (item_we)
        begin
            fwd_addr_reg <= s1_addr_reg;
            fwd_data_reg <= new_val;
        end
        if (s1_commit)
        begin
            out_index_reg   <= s1_inside_reg ? casb_pkg::idx_t'(s1_addr_reg) : '0;
            out_value_reg   <= s1_inside_reg ? new_val : '0;
            out_written_reg <= s1_inside_reg;
            out_last_reg    <= s1_last_reg;
        end
    end

    // ---------------------------------------------------------------- outputs
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {out_value_reg, out_index_reg};
    assign m_axis_tuser  = out_written_reg;
    assign m_axis_tlast  = out_last_reg;

endmodule
